// ----- src/tphc_pkg.sv -----
// ----------------------------------------------------------------------------
// tphc_pkg
// Shared types, constants and the FNV-1a fold function for the prefix hash
// lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package tphc_pkg;

  // 64-bit FNV-1a constants.
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME_LO = 64'd435;   // prime = 2^40 + 435
  localparam int unsigned FNV_PRIME_SHIFT = 40;

  // Result status codes.
  localparam logic [1:0] STATUS_HIT      = 2'd0;
  localparam logic [1:0] STATUS_INSERTED = 2'd1;
  localparam logic [1:0] STATUS_MISS     = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  // Reset value of the entry limit register.
  localparam logic [6:0] ENTRY_LIMIT_RESET = 7'd64;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_SEARCH,
    S_DONE
  } tphc_state_e;

  // One stored table entry.
  typedef struct packed {
    logic [63:0] key;
    logic [14:0] blk;
  } tphc_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted word, seed on first
    logic fold;        // fold the captured token into the hash
    logic scan_start;  // reset the search pointer
    logic scan_rd;     // issue one table read
    logic hit_cap;     // capture the matching entry
    logic finish;      // load the result register, insert on a miss unless op is set or the table is full
  } tphc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;         // captured word ends the request
    logic scan_more;    // entries remain to be read
    logic cmp_pending;  // a read result is being compared this cycle
    logic cmp_hit;      // the compared entry matches the key
  } tphc_stat_t;

  // One FNV-1a step: (h ^ v) * prime, with the prime split into a shift and a
  // small constant multiply.
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [63:0] v);
    logic [63:0] x;
    x = h ^ v;
    return (x << FNV_PRIME_SHIFT) + (x * FNV_PRIME_LO);
  endfunction

endpackage

`default_nettype wire

// ----- src/tphc_ram.sv -----
// ----------------------------------------------------------------------------
// tphc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tphc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/tphc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tphc_ctrl
// Controller: sequences accept, fold, table search and result delivery, and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tphc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tphc_pkg::tphc_cmd_t      cmd_o,
  input  wire tphc_pkg::tphc_stat_t stat_i
);

  tphc_pkg::tphc_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tphc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = tphc_pkg::S_FOLD;
        end
      end
      tphc_pkg::S_FOLD: begin
        state_d = stat_i.last ? tphc_pkg::S_SEARCH : tphc_pkg::S_IDLE;
      end
      tphc_pkg::S_SEARCH: begin
        if (stat_i.cmp_hit || (!stat_i.scan_more && !stat_i.cmp_pending)) begin
          state_d = tphc_pkg::S_DONE;
        end
      end
      tphc_pkg::S_DONE: begin
        if (out_free) begin
          state_d = tphc_pkg::S_IDLE;
        end
      end
      default: state_d = tphc_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tphc_pkg::S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      tphc_pkg::S_FOLD: begin
        cmd_o.fold       = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      tphc_pkg::S_SEARCH: begin
        cmd_o.scan_rd = stat_i.scan_more && !stat_i.cmp_hit;
        cmd_o.hit_cap = stat_i.cmp_hit;
      end
      tphc_pkg::S_DONE: begin
        cmd_o.finish = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tphc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result only ever comes from the completion state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == tphc_pkg::S_DONE)
    else $error("result valid rose outside the completion state");

  // A search always ends in the completion state.
  a_search_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tphc_pkg::S_SEARCH |=>
      (state_q == tphc_pkg::S_SEARCH || state_q == tphc_pkg::S_DONE))
    else $error("search left to an unexpected state");

  // An accepted word is always folded in the next cycle.
  a_accept_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tphc_pkg::S_IDLE && in_valid_i) |=> state_q == tphc_pkg::S_FOLD)
    else $error("accepted word was not folded");

  // No table read is issued once a match has been seen.
  a_no_read_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.hit_cap |-> !cmd_o.scan_rd && state_d == tphc_pkg::S_DONE)
    else $error("table read issued on a hit");

endmodule

`default_nettype wire

// ----- src/tphc_dp.sv -----
// ----------------------------------------------------------------------------
// tphc_dp
// Datapath: hash state, token fold, table search pointer, entry RAM and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tphc_dp #(
  parameter int unsigned MaxEntries = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [6:0]          cfg_wdata_i,
  input  wire logic                op_i,
  input  wire logic                first_i,
  input  wire logic                last_i,
  input  wire logic signed [31:0]  token_i,
  input  wire logic [15:0]         prefix_len_i,
  input  wire logic [9:0]          layer_i,
  input  wire logic signed [15:0]  requested_block_i,
  input  wire tphc_pkg::tphc_cmd_t cmd_i,
  output tphc_pkg::tphc_stat_t     stat_o,
  output logic [1:0]               status_o,
  output logic signed [15:0]       block_ref_o,
  output logic [63:0]              prefix_key_o,
  output logic [15:0]              tokens_hashed_o
);

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned LimW = (CntW > 7) ? CntW : 7;

  // Request state.
  logic [63:0]     hash_q, hash_d;
  logic [15:0]     seen_q, seen_d;
  logic            op_q, op_d;
  logic [15:0]     len_q, len_d;
  logic [CntW-1:0] used_q, used_d;
  logic [6:0]      limit_q;

  // Captured word.
  logic [31:0] tok_q;
  logic        last_q;
  logic [15:0] req_q;

  // Search state.
  logic [CntW-1:0] scan_q;
  logic            cmp_valid_q;
  logic            hit_q;
  logic [14:0]     hit_blk_q;

  // Result register.
  logic [1:0]  status_q;
  logic [15:0] ref_q;
  logic [63:0] key_q;
  logic [15:0] cnt_q;

  tphc_pkg::tphc_entry_t rd_entry, wr_entry;
  logic        full;
  logic        insert;
  logic [15:0] ins_blk;
  logic [1:0]  res_status;
  logic [15:0] res_ref;
  logic [63:0] tok_ext;

  // Table is full at the configured limit or at the physical depth.
  assign full = (LimW'(used_q) >= LimW'(limit_q)) ||
                (LimW'(used_q) >= LimW'(MaxEntries));

  // A negative requested id stores the entry index instead.
  assign ins_blk = req_q[15] ? 16'(used_q) : req_q;
  assign insert  = cmd_i.finish && !hit_q && !op_q && !full;

  // Result selection.
  always_comb begin
    if (hit_q) begin
      res_status = tphc_pkg::STATUS_HIT;
      res_ref    = {1'b0, hit_blk_q};
    end else if (op_q) begin
      res_status = tphc_pkg::STATUS_MISS;
      res_ref    = 16'hFFFF;
    end else if (full) begin
      res_status = tphc_pkg::STATUS_FULL;
      res_ref    = 16'hFFFF;
    end else begin
      res_status = tphc_pkg::STATUS_INSERTED;
      res_ref    = ins_blk;
    end
  end

  // Hash update: seed on a first word, then fold one token per word while fewer than prefix_len tokens are folded.
  assign tok_ext = {{32{tok_q[31]}}, tok_q} + 64'd1;

  always_comb begin
    hash_d = hash_q;
    seen_d = seen_q;
    op_d   = op_q;
    len_d  = len_q;
    used_d = used_q;
    if (cmd_i.load_item && first_i) begin
      hash_d = tphc_pkg::fnv_fold(tphc_pkg::FNV_BASIS, {54'd0, layer_i} + 64'd1);
      seen_d = '0;
      op_d   = op_i;
      len_d  = prefix_len_i;
    end
    if (cmd_i.fold && (seen_q < len_q)) begin
      hash_d = tphc_pkg::fnv_fold(hash_q, tok_ext);
      seen_d = seen_q + 16'd1;
    end
    if (insert) begin
      used_d = used_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= tphc_pkg::FNV_BASIS;
      seen_q  <= '0;
      op_q    <= 1'b0;
      len_q   <= '0;
      used_q  <= '0;
      limit_q <= tphc_pkg::ENTRY_LIMIT_RESET;
    end else begin
      hash_q <= hash_d;
      seen_q <= seen_d;
      op_q   <= op_d;
      len_q  <= len_d;
      used_q <= used_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // Search pointer and compare pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      cmp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      cmp_valid_q <= cmd_i.scan_rd;
      if (cmd_i.scan_start) begin
        scan_q      <= '0;
        cmp_valid_q <= 1'b0;
        hit_q       <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_q <= scan_q + CntW'(1);
        end
        if (cmd_i.hit_cap) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers: captured word, hit entry and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      tok_q  <= token_i;
      last_q <= last_i;
      req_q  <= requested_block_i;
    end
    if (cmd_i.hit_cap) begin
      hit_blk_q <= rd_entry.blk;
    end
    if (cmd_i.finish) begin
      status_q <= res_status;
      ref_q    <= res_ref;
      key_q    <= hash_q;
      cnt_q    <= seen_q;
    end
  end

  // Entry table: key and block id of each allocated entry.
  assign wr_entry.key = hash_q;
  assign wr_entry.blk = ins_blk[14:0];

  tphc_ram #(
    .Width ($bits(tphc_pkg::tphc_entry_t)),
    .Depth (MaxEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (insert),
    .waddr_i (used_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // Status to the controller.
  assign stat_o.last        = last_q;
  assign stat_o.scan_more   = scan_q < used_q;
  assign stat_o.cmp_pending = cmp_valid_q;
  assign stat_o.cmp_hit     = cmp_valid_q && (rd_entry.key == hash_q);

  assign status_o        = status_q;
  assign block_ref_o     = ref_q;
  assign prefix_key_o    = key_q;
  assign tokens_hashed_o = cnt_q;

endmodule

`default_nettype wire

// ----- src/token_prefix_hash_cache.sv -----
// ----------------------------------------------------------------------------
// token_prefix_hash_cache
// Prefix hash lookup table: folds request tokens into a 64-bit FNV-1a key and
// looks the key up in, or inserts it into, an entry table.
// ----------------------------------------------------------------------------
// Each accepted word is first captured (seeding the hash with the layer on a
// first word), and then its token is folded into the key. A word marked last
// goes on to scan the entry table one entry per cycle through the RAM's single
// registered read port, and its result is loaded once the result register is
// empty or being drained. The result register lets the next word be accepted
// while a result waits to be taken. The table needs no clearing after reset;
// only allocated entries are ever searched.
`default_nettype none

module token_prefix_hash_cache #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration: entry limit.
  input  wire logic               cfg_we_i,
  input  wire logic [6:0]         cfg_wdata_i,
  // Input words.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic               first_i,
  input  wire logic               last_i,
  input  wire logic signed [31:0] token_i,
  input  wire logic [15:0]        prefix_len_i,
  input  wire logic [9:0]         layer_i,
  input  wire logic signed [15:0] requested_block_i,
  // Result words.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [15:0]      block_ref_o,
  output logic [63:0]             prefix_key_o,
  output logic [15:0]             tokens_hashed_o
);

  tphc_pkg::tphc_cmd_t  cmd;
  tphc_pkg::tphc_stat_t stat;

  // Sequencing.
  tphc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Hashing, table and result.
  tphc_dp #(
    .MaxEntries (MAX_ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .op_i              (op_i),
    .first_i           (first_i),
    .last_i            (last_i),
    .token_i           (token_i),
    .prefix_len_i      (prefix_len_i),
    .layer_i           (layer_i),
    .requested_block_i (requested_block_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .block_ref_o       (block_ref_o),
    .prefix_key_o      (prefix_key_o),
    .tokens_hashed_o   (tokens_hashed_o)
  );

endmodule

`default_nettype wire
